>>> hw/rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue core.
// Used by double_ended_queue_core; no dependencies.
package dq_pkg;

  localparam int unsigned Depth     = 64;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrWidth = $clog2(Depth);
  localparam int unsigned CntWidth  = $clog2(Depth + 1);

  // request codes; codes above FuncRead are ignored
  localparam logic [2:0] FuncPushFront = 3'd0;
  localparam logic [2:0] FuncPushBack  = 3'd1;
  localparam logic [2:0] FuncPopFront  = 3'd2;
  localparam logic [2:0] FuncPopBack   = 3'd3;
  localparam logic [2:0] FuncRead      = 3'd4;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2,
    StatusRange = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] data_in;
    logic [5:0]  index;
  } in_word_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [1:0]  status;
    logic [6:0]  entry_count;
  } out_word_t;

endpackage

>>> hw/rtl/dq_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Standalone; no package dependencies.
module dq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/double_ended_queue_core.sv
// Double-ended queue core: ring buffer held in one synchronous RAM.
// Depends on dq_pkg and dq_ram.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) takes one request:
//   push front, push back, pop front, pop back or read at an index counted
//   from the front. Output channel (out_valid_o / out_stall_i / out_word_o)
//   returns exactly one word per request: data, status and entry count.
//   Pushes, refused requests and ignored codes update the pointers at the
//   accepting edge and present their result on the next cycle, so they
//   sustain one request per cycle while the output is not stalled. Pops and
//   reads issue a RAM read at the accepting edge; the registered read data
//   is taken into the output register at the next edge, so a successful pop
//   or read stalls the input while its read is pending. The RAM's registered
//   read data sets this.
//   A stalled output holds its word and stalls the input until the word
//   leaves; a word that leaves at an edge frees the register for the request
//   accepted at that same edge.
//   Reset clears the front pointer and the entry count; the RAM contents are
//   not cleared and are only read at positions that a push has written.
module double_ended_queue_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dq_pkg::in_word_t   in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dq_pkg::out_word_t  out_word_o
);

  localparam int unsigned AW = dq_pkg::AddrWidth;
  localparam int unsigned CW = dq_pkg::CntWidth;
  localparam int unsigned DW = dq_pkg::DataWidth;

  logic [AW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  dq_pkg::out_word_t out_q, out_d;

  logic          accept;
  logic          is_full, is_empty, out_free;
  logic [CW-1:0] offset;
  logic [AW-1:0] slot;
  logic [CW:0]   slot_sum;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [DW-1:0] ram_rdata;
  logic [AW-1:0] front_dec, front_inc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = pend_q || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_full  = (count_q == CW'(dq_pkg::Depth));
  assign is_empty = (count_q == '0);

  assign front_dec = (front_q == '0) ? AW'(dq_pkg::Depth - 1) : front_q - 1'b1;
  assign front_inc = (front_q == AW'(dq_pkg::Depth - 1)) ? '0 : front_q + 1'b1;

  // offset from the front of the entry a request touches
  always_comb begin
    unique case (in_word_i.func)
      dq_pkg::FuncPushBack: offset = count_q;
      dq_pkg::FuncPopBack:  offset = count_q - 1'b1;
      dq_pkg::FuncRead:     offset = CW'(in_word_i.index);
      default:              offset = '0;
    endcase
  end

  // wrap front + offset into the ring
  assign slot_sum = (CW + 1)'(front_q) + (CW + 1)'(offset);
  assign slot = (slot_sum >= (CW + 1)'(dq_pkg::Depth))
                ? AW'(slot_sum - (CW + 1)'(dq_pkg::Depth)) : AW'(slot_sum);

  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    pend_d      = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = slot;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (pend_q) begin
      // read data arrives; count already reflects the pop
      out_valid_d          = 1'b1;
      out_d.data_out       = 32'(ram_rdata);
      out_d.status         = dq_pkg::StatusOk;
      out_d.entry_count    = 7'(count_q);
    end else if (accept) begin
      out_d.data_out = '0;
      out_d.status   = dq_pkg::StatusOk;
      out_valid_d    = 1'b1;
      unique case (in_word_i.func)
        dq_pkg::FuncPushFront: begin
          if (is_full) begin
            out_d.status = dq_pkg::StatusFull;
          end else begin
            front_d  = front_dec;
            count_d  = count_q + 1'b1;
            ram_we   = 1'b1;
            ram_addr = front_dec;
          end
        end
        dq_pkg::FuncPushBack: begin
          if (is_full) begin
            out_d.status = dq_pkg::StatusFull;
          end else begin
            count_d = count_q + 1'b1;
            ram_we  = 1'b1;
          end
        end
        dq_pkg::FuncPopFront: begin
          if (is_empty) begin
            out_d.status = dq_pkg::StatusEmpty;
          end else begin
            ram_re      = 1'b1;
            ram_addr    = front_q;
            front_d     = front_inc;
            count_d     = count_q - 1'b1;
            pend_d      = 1'b1;
            out_valid_d = 1'b0;
          end
        end
        dq_pkg::FuncPopBack: begin
          if (is_empty) begin
            out_d.status = dq_pkg::StatusEmpty;
          end else begin
            ram_re      = 1'b1;
            count_d     = count_q - 1'b1;
            pend_d      = 1'b1;
            out_valid_d = 1'b0;
          end
        end
        dq_pkg::FuncRead: begin
          if (CW'(in_word_i.index) >= count_q) begin
            out_d.status = dq_pkg::StatusRange;
          end else begin
            ram_re      = 1'b1;
            pend_d      = 1'b1;
            out_valid_d = 1'b0;
          end
        end
        default: begin
          // unused code: report ok with unchanged count
        end
      endcase
      out_d.entry_count = 7'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  dq_ram #(
    .Width (DW),
    .Depth (dq_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (DW'(in_word_i.data_in)),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
